/* rtl/sqllex_pkg.sv */
// ----------------------------------------------------------------------------
// sqllex_pkg
// Shared types, character codes and lexing functions for the SQL lexer.
// ----------------------------------------------------------------------------
package sqllex_pkg;

    // result kinds
    localparam logic [2:0] KIND_SYMBOL = 3'd0;
    localparam logic [2:0] KIND_STRING = 3'd1;
    localparam logic [2:0] KIND_NUMBER = 3'd2;
    localparam logic [2:0] KIND_BOOL   = 3'd3;
    localparam logic [2:0] KIND_IDENT  = 3'd4;
    localparam logic [2:0] KIND_EOT    = 3'd5;
    localparam logic [2:0] KIND_ERROR  = 3'd6;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    localparam logic [7:0] WordTrue  [4] = '{8'h54, 8'h52, 8'h55, 8'h45};
    localparam logic [7:0] WordFalse [5] = '{8'h46, 8'h41, 8'h4C, 8'h53, 8'h45};
    localparam logic [2:0] WordLenSat = 3'd6;

    // results per item and command queue sizing
    localparam int MaxRes   = 4;
    localparam int ResIdxW  = $clog2(MaxRes);
    localparam int ResCntW  = $clog2(MaxRes + 1);
    localparam int CmdDepth = 4;
    localparam int CmdPtrW  = $clog2(CmdDepth);
    localparam int CmdCntW  = $clog2(CmdDepth + 1);

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_STRING = 3'd1,
        MODE_NUMBER = 3'd2,
        MODE_WORD   = 3'd3,
        MODE_PEND   = 3'd4,
        MODE_ERROR  = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_LT   = 2'd1,
        OP_GT   = 2'd2,
        OP_BANG = 2'd3
    } t_op;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_char;
        logic       has_char;
        logic       token_end;
        logic       last;
    } t_out;

    typedef struct packed {
        t_mode      mode;
        logic       quote_dbl;
        logic       seen_dot;
        t_op        pend_op;
        logic [2:0] word_len;
        logic       may_true;
        logic       may_false;
    } t_lex_state;

    // results of one item, packed for the queue
    typedef struct packed {
        logic [ResCntW-1:0]      count;
        t_out [MaxRes-1:0]       res;
    } t_cmd;

    typedef struct packed {
        t_lex_state st;
        t_cmd       cmd;
    } t_step;

    function automatic logic is_space(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
    endfunction

    function automatic t_lex_state go_idle(t_lex_state s);
        t_lex_state r;
        r           = s;
        r.mode      = MODE_IDLE;
        r.pend_op   = OP_NONE;
        r.seen_dot  = 1'b0;
        r.word_len  = 3'd0;
        r.may_true  = 1'b1;
        r.may_false = 1'b1;
        return r;
    endfunction

    function automatic t_step add_res(t_step x, logic [2:0] kind, logic [7:0] c,
                                      logic has, logic fin);
        t_step r;
        r = x;
        r.cmd.res[r.cmd.count[ResIdxW-1:0]] =
            '{kind: kind, out_char: c, has_char: has, token_end: fin, last: 1'b0};
        r.cmd.count = r.cmd.count + ResCntW'(1);
        return r;
    endfunction

    function automatic t_step word_char(t_step x, logic [7:0] c);
        logic [7:0] u;
        t_step      r;
        u = (c >= CH_LA && c <= CH_LZ) ? c - CASE_GAP : c;
        r = x;
        if (r.st.word_len < 3'd4) begin
            if (u != WordTrue[r.st.word_len[1:0]]) r.st.may_true = 1'b0;
        end else begin
            r.st.may_true = 1'b0;
        end
        if (r.st.word_len < 3'd5) begin
            if (u != WordFalse[r.st.word_len]) r.st.may_false = 1'b0;
        end else begin
            r.st.may_false = 1'b0;
        end
        if (r.st.word_len < WordLenSat) r.st.word_len = r.st.word_len + 3'd1;
        return add_res(r, KIND_IDENT, u, 1'b1, 1'b0);
    endfunction

    function automatic logic [2:0] word_kind(t_lex_state s);
        if ((s.word_len == 3'd4 && s.may_true) || (s.word_len == 3'd5 && s.may_false))
            return KIND_BOOL;
        return KIND_IDENT;
    endfunction

    function automatic logic [7:0] op_byte(t_op op);
        if (op == OP_LT) return CH_LT;
        if (op == OP_GT) return CH_GT;
        return CH_BANG;
    endfunction

    function automatic t_step start_token(t_step x, logic [7:0] c);
        t_step r;
        r = x;
        if (is_space(c)) begin
            return r;
        end else if (c == CH_LT || c == CH_GT || c == CH_BANG) begin
            r.st.mode    = MODE_PEND;
            r.st.pend_op = (c == CH_LT) ? OP_LT : (c == CH_GT) ? OP_GT : OP_BANG;
        end else if (c == CH_COMMA || c == CH_LPAREN || c == CH_RPAREN || c == CH_EQ ||
                     c == CH_STAR || c == CH_DOT || c == CH_SEMI) begin
            r = add_res(r, KIND_SYMBOL, c, 1'b1, 1'b0);
            r = add_res(r, KIND_SYMBOL, CH_NUL, 1'b0, 1'b1);
        end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            r.st.mode      = MODE_STRING;
            r.st.quote_dbl = (c == CH_DQUOTE);
        end else if (is_digit(c)) begin
            r.st.mode     = MODE_NUMBER;
            r.st.seen_dot = 1'b0;
            r = add_res(r, KIND_NUMBER, c, 1'b1, 1'b0);
        end else if (is_alpha(c) || c == CH_UNDER) begin
            r.st.mode      = MODE_WORD;
            r.st.word_len  = 3'd0;
            r.st.may_true  = 1'b1;
            r.st.may_false = 1'b1;
            r = word_char(r, c);
        end else begin
            r.st.mode = MODE_ERROR;
            r = add_res(r, KIND_ERROR, c, 1'b0, 1'b1);
        end
        return r;
    endfunction

    function automatic t_step on_byte(t_step x, logic [7:0] c);
        t_step      r;
        logic [7:0] op_c;
        r    = x;
        op_c = op_byte(r.st.pend_op);
        unique case (r.st.mode)
            MODE_ERROR: begin
            end
            MODE_STRING: begin
                if (c == (r.st.quote_dbl ? CH_DQUOTE : CH_SQUOTE)) begin
                    r.st = go_idle(r.st);
                    r = add_res(r, KIND_STRING, CH_NUL, 1'b0, 1'b1);
                end else begin
                    r = add_res(r, KIND_STRING, c, 1'b1, 1'b0);
                end
            end
            MODE_NUMBER: begin
                if (is_digit(c)) begin
                    r = add_res(r, KIND_NUMBER, c, 1'b1, 1'b0);
                end else if (c == CH_DOT && !r.st.seen_dot) begin
                    r.st.seen_dot = 1'b1;
                    r = add_res(r, KIND_NUMBER, c, 1'b1, 1'b0);
                end else begin
                    r = add_res(r, KIND_NUMBER, CH_NUL, 1'b0, 1'b1);
                    r.st = go_idle(r.st);
                    r = start_token(r, c);
                end
            end
            MODE_WORD: begin
                if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
                    r = word_char(r, c);
                end else begin
                    r = add_res(r, word_kind(r.st), CH_NUL, 1'b0, 1'b1);
                    r.st = go_idle(r.st);
                    r = start_token(r, c);
                end
            end
            MODE_PEND: begin
                if (c == CH_EQ) begin
                    r = add_res(r, KIND_SYMBOL, op_c, 1'b1, 1'b0);
                    r = add_res(r, KIND_SYMBOL, CH_EQ, 1'b1, 1'b0);
                    r.st = go_idle(r.st);
                    r = add_res(r, KIND_SYMBOL, CH_NUL, 1'b0, 1'b1);
                end else if (r.st.pend_op == OP_BANG || r.st.pend_op == OP_NONE) begin
                    // lone bang: the byte after it is dropped
                    r.st      = go_idle(r.st);
                    r.st.mode = MODE_ERROR;
                    r = add_res(r, KIND_ERROR, CH_BANG, 1'b0, 1'b1);
                end else begin
                    r = add_res(r, KIND_SYMBOL, op_c, 1'b1, 1'b0);
                    r = add_res(r, KIND_SYMBOL, CH_NUL, 1'b0, 1'b1);
                    r.st = go_idle(r.st);
                    r = start_token(r, c);
                end
            end
            default: begin
                r.st = go_idle(r.st);
                r = start_token(r, c);
            end
        endcase
        return r;
    endfunction

    function automatic t_step on_end(t_step x);
        t_step      r;
        logic [7:0] op_c;
        r    = x;
        op_c = op_byte(r.st.pend_op);
        unique case (r.st.mode)
            MODE_ERROR: begin
                r.st = go_idle(r.st);
                return r;
            end
            MODE_STRING: begin
                // unterminated string: error only, no end-of-text result
                r.st = go_idle(r.st);
                return add_res(r, KIND_ERROR, CH_NUL, 1'b0, 1'b1);
            end
            MODE_NUMBER: r = add_res(r, KIND_NUMBER, CH_NUL, 1'b0, 1'b1);
            MODE_WORD:   r = add_res(r, word_kind(r.st), CH_NUL, 1'b0, 1'b1);
            MODE_PEND: begin
                if (r.st.pend_op == OP_BANG || r.st.pend_op == OP_NONE) begin
                    r.st = go_idle(r.st);
                    return add_res(r, KIND_ERROR, CH_BANG, 1'b0, 1'b1);
                end
                r = add_res(r, KIND_SYMBOL, op_c, 1'b1, 1'b0);
                r = add_res(r, KIND_SYMBOL, CH_NUL, 1'b0, 1'b1);
            end
            default: begin
            end
        endcase
        r.st = go_idle(r.st);
        return add_res(r, KIND_EOT, CH_NUL, 1'b0, 1'b1);
    endfunction

endpackage

/* rtl/sqllex_front.sv */
// ----------------------------------------------------------------------------
// sqllex_front
// Accepts text bytes, runs the lexer state and packs each item's results
// into one command for the queue.
// ----------------------------------------------------------------------------
module sqllex_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sqllex_pkg::t_in      i_data,
    output logic                 o_full,
    input  logic                 i_q_full,
    output logic                 o_q_wr,
    output sqllex_pkg::t_cmd     o_q_cmd
);

    sqllex_pkg::t_lex_state r_st;
    sqllex_pkg::t_lex_state n_st;
    sqllex_pkg::t_step      w_step;
    logic                   w_accept;
    logic [sqllex_pkg::ResIdxW-1:0] w_last_idx;

    assign o_full   = i_q_full;
    assign w_accept = i_push && !i_q_full;

    always_comb begin
        w_step.st  = r_st;
        w_step.cmd = '0;
        if (i_data.end_of_text) begin
            w_step = sqllex_pkg::on_end(w_step);
        end else begin
            w_step = sqllex_pkg::on_byte(w_step, i_data.ch);
        end
        w_last_idx = sqllex_pkg::ResIdxW'(w_step.cmd.count - sqllex_pkg::ResCntW'(1));
        if (w_step.cmd.count != '0) w_step.cmd.res[w_last_idx].last = 1'b1;
        n_st = w_accept ? w_step.st : r_st;
    end

    // items that give no result never enter the queue
    assign o_q_wr  = w_accept && (w_step.cmd.count != '0);
    assign o_q_cmd = w_step.cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '{mode: sqllex_pkg::MODE_IDLE, quote_dbl: 1'b0, seen_dot: 1'b0,
                      pend_op: sqllex_pkg::OP_NONE, word_len: 3'd0, may_true: 1'b1,
                      may_false: 1'b1};
        end else begin
            r_st <= n_st;
        end
    end

endmodule

/* rtl/sqllex_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// sqllex_cmd_fifo
// Short command queue between the lexer front and the result back end.
// ----------------------------------------------------------------------------
module sqllex_cmd_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  sqllex_pkg::t_cmd i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output sqllex_pkg::t_cmd o_rdata,
    output logic             o_empty
);

    sqllex_pkg::t_cmd                r_mem [sqllex_pkg::CmdDepth];
    logic [sqllex_pkg::CmdPtrW-1:0]  r_wp;
    logic [sqllex_pkg::CmdPtrW-1:0]  r_rp;
    logic [sqllex_pkg::CmdCntW-1:0]  r_cnt;

    assign o_full  = r_cnt == sqllex_pkg::CmdCntW'(sqllex_pkg::CmdDepth);
    assign o_empty = r_cnt == '0;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= r_wp + sqllex_pkg::CmdPtrW'(1);
            if (i_rd) r_rp <= r_rp + sqllex_pkg::CmdPtrW'(1);
            r_cnt <= r_cnt + sqllex_pkg::CmdCntW'(i_wr) - sqllex_pkg::CmdCntW'(i_rd);
        end
    end

endmodule

/* rtl/sqllex_back.sv */
// ----------------------------------------------------------------------------
// sqllex_back
// Walks the results of the head command into the output register, one a
// cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module sqllex_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sqllex_pkg::t_cmd i_head,
    input  logic             i_q_empty,
    output logic             o_q_rd,
    input  logic             i_pop,
    output sqllex_pkg::t_out o_data,
    output logic             o_empty
);

    logic [sqllex_pkg::ResIdxW-1:0] r_idx;
    logic [sqllex_pkg::ResIdxW-1:0] n_idx;
    logic                           r_vld;
    logic                           n_vld;
    sqllex_pkg::t_out               r_out;
    logic                           w_take;
    logic                           w_load;
    logic                           w_head_last;

    always_comb begin
        // output slot is free or being taken this cycle
        w_take      = !r_vld || i_pop;
        w_load      = w_take && !i_q_empty;
        w_head_last = (sqllex_pkg::ResCntW'(r_idx) + sqllex_pkg::ResCntW'(1)) == i_head.count;
        n_vld       = w_take ? !i_q_empty : r_vld;
        n_idx       = r_idx;
        if (w_load) n_idx = w_head_last ? '0 : r_idx + sqllex_pkg::ResIdxW'(1);
    end

    assign o_q_rd  = w_load && w_head_last;
    assign o_data  = r_out;
    assign o_empty = !r_vld;

    always_ff @(posedge i_clk) begin
        if (w_load) r_out <= i_head.res[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= '0;
        end else begin
            r_vld <= n_vld;
            r_idx <= n_idx;
        end
    end

endmodule

/* rtl/sql_token_lexer.sv */
// ----------------------------------------------------------------------------
// sql_token_lexer
// Streaming SQL lexer: text bytes in, token characters and closing results out.
// ----------------------------------------------------------------------------
//  channel  | handshake         | payload
//  ---------+-------------------+-------------------------------------------
//  input    | push / full       | i_data : ch, end_of_text
//  result   | pop / empty       | o_data : kind, out_char, has_char,
//           |                   |          token_end, last
//
// One item is taken per cycle while the four-entry command queue has room.
// Results leave at one per cycle from the output register while pop is high
// or the register is empty; an item gives at most four results.
// With the back end idle, an item's first result reaches the ports through
// the command queue and then the output register.
// Synchronous reset clears lexer state, empties the queue and marks the output register empty.
// Pop held low stalls the back end only; the front keeps filling the queue until it is full.
// ----------------------------------------------------------------------------
module sql_token_lexer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    input  sqllex_pkg::t_in  i_data,
    output logic             full,
    input  logic             pop,
    output sqllex_pkg::t_out o_data,
    output logic             empty
);

    logic             w_q_full;
    logic             w_q_wr;
    sqllex_pkg::t_cmd w_q_wdata;
    logic             w_q_rd;
    sqllex_pkg::t_cmd w_q_head;
    logic             w_q_empty;

    sqllex_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (i_data),
        .o_full  (full),
        .i_q_full(w_q_full),
        .o_q_wr  (w_q_wr),
        .o_q_cmd (w_q_wdata)
    );

    sqllex_cmd_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (w_q_wr),
        .i_wdata(w_q_wdata),
        .o_full (w_q_full),
        .i_rd   (w_q_rd),
        .o_rdata(w_q_head),
        .o_empty(w_q_empty)
    );

    sqllex_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_q_head),
        .i_q_empty(w_q_empty),
        .o_q_rd   (w_q_rd),
        .i_pop    (pop),
        .o_data   (o_data),
        .o_empty  (empty)
    );

endmodule

/* rtl/sql_token_lexer_chk.sv */
// ----------------------------------------------------------------------------
// sql_token_lexer_chk
// Port-level checks on the lexer, bound to the top level.
// ----------------------------------------------------------------------------
module sql_token_lexer_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             push,
    input sqllex_pkg::t_in  i_data,
    input logic             full,
    input logic             pop,
    input sqllex_pkg::t_out o_data,
    input logic             empty
);

    // reset leaves nothing to deliver and room for input
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("lexer not clear after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty && $stable(o_data))
        else $error("stalled result changed");

    // a result carries a character or closes a token, never both
    a_char_or_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_data.has_char && o_data.token_end))
        else $error("result both carries a character and closes");

    a_error_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_data.kind == sqllex_pkg::KIND_ERROR || o_data.kind == sqllex_pkg::KIND_EOT
                    || o_data.kind == sqllex_pkg::KIND_BOOL))
        |-> o_data.token_end && !o_data.has_char)
        else $error("error, end or boolean result without close");

    a_close_last_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_data.has_char && o_data.last) |-> o_data.kind != sqllex_pkg::KIND_SYMBOL
        || o_data.out_char == sqllex_pkg::CH_EQ || o_data.out_char == sqllex_pkg::CH_LT
        || o_data.out_char == sqllex_pkg::CH_GT)
        else $error("symbol character ends an item without its close");

endmodule

bind sql_token_lexer sql_token_lexer_chk u_chk (.*);
